// ----- design/htw_pkg.sv -----
`timescale 1ns / 1ps

package htw_pkg;

  // Request field widths
  localparam int unsigned REQ_W        = 2;
  localparam int unsigned ID_W         = 5;
  localparam int unsigned TIMEOUT_BITS = 20;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((ID_W + TIMEOUT_BITS + 1 + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W = ((ID_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_ADJUST = 2'd2,
    REQ_TICK   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ARM,
    ST_PRIME,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic arm_wr;
    logic prime;
    logic scan;
    logic flush;
  } htw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_tick;
    logic req_arm;
    logic id_ok;
    logic div_done;
    logic scan_end;
    logic flush_ok;
  } htw_sts_t;

endpackage

// ----- design/htw_ram.sv -----
`timescale 1ns / 1ps

module htw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/htw_ctrl.sv -----
`timescale 1ns / 1ps

module htw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  htw_pkg::htw_sts_t sts_i,
  output htw_pkg::htw_cmd_t cmd_o
);

  import htw_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          if (sts_i.req_tick) begin
            state_d = ST_PRIME;
          end else if (sts_i.req_arm && sts_i.id_ok) begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_ARM;
        end
      end
      ST_ARM: begin
        cmd_o.arm_wr = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_PRIME: begin
        cmd_o.prime = 1'b1;
        state_d     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        if (sts_i.flush_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/htw_datapath.sv -----
`timescale 1ns / 1ps

module htw_datapath #(
  parameter int unsigned SLOTS  = 1024,
  parameter int unsigned TIMERS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  htw_pkg::htw_cmd_t                cmd_i,
  output htw_pkg::htw_sts_t                sts_o,
  input  logic [htw_pkg::IN_DATA_W-1:0]    in_data_i,
  input  logic [htw_pkg::REQ_W-1:0]        in_user_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [htw_pkg::OUT_DATA_W-1:0]   out_data_o,
  output logic                             out_last_o
);

  import htw_pkg::*;

  localparam int unsigned     SLOT_W    = $clog2(SLOTS);
  localparam longint unsigned MAX_TICKS = (64'd1 << TIMEOUT_BITS) - 64'd1;
  localparam int unsigned     ROT_W     = $clog2(MAX_TICKS / SLOTS + 1);
  localparam int unsigned     TIDX_W    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
  localparam int unsigned     CNT_W     = 2;

  // Reciprocal of SLOTS scaled by 2^RCP_SH, rounded up; exact for every delay
  localparam int unsigned     RCP_SH    = TIMEOUT_BITS + SLOT_W;
  localparam int unsigned     RCP_W     = TIMEOUT_BITS + 2;
  localparam int unsigned     PROD_W    = TIMEOUT_BITS + RCP_W;
  localparam longint unsigned RCP_V     = ((64'd1 << RCP_SH) + SLOTS - 1) / SLOTS;

  localparam logic [SLOT_W:0]       SLOTS_V   = (SLOT_W + 1)'(SLOTS);
  localparam logic [SLOT_W-1:0]     LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam logic [TIDX_W-1:0]     LAST_IDX  = TIDX_W'(TIMERS - 1);
  localparam logic [ID_W+1:0]       TIMERS_V  = (ID_W + 2)'(TIMERS);
  localparam logic [CNT_W-1:0]      DIV_STEPS = CNT_W'(2);
  localparam logic [RCP_W-1:0]      RCP       = RCP_W'(RCP_V);
  localparam logic [TIMEOUT_BITS-1:0] SLOTS_T = TIMEOUT_BITS'(SLOTS);

  typedef struct packed {
    logic              per;
    logic [ROT_W-1:0]  reload;
    logic [SLOT_W-1:0] offset;
    logic [SLOT_W-1:0] slot;
    logic [ROT_W-1:0]  rot;
  } entry_t;

  localparam int unsigned ENT_W = $bits(entry_t);

  // (a + b) mod SLOTS for a, b already below SLOTS
  function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                 input logic [SLOT_W-1:0] b);
    logic [SLOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SLOTS_V) begin
      s = s - SLOTS_V;
    end
    return s[SLOT_W-1:0];
  endfunction

  // Input field decode
  req_e                    in_req;
  logic [ID_W-1:0]         in_id;
  logic [TIMEOUT_BITS-1:0] in_tmo;
  logic                    in_per;
  logic                    in_id_ok;

  assign in_req   = req_e'(in_user_i);
  assign in_id    = in_data_i[ID_W-1:0];
  assign in_tmo   = in_data_i[ID_W +: TIMEOUT_BITS];
  assign in_per   = in_data_i[ID_W + TIMEOUT_BITS];
  assign in_id_ok = {2'b00, in_id} < TIMERS_V;

  // Request and divider registers
  logic [TIDX_W-1:0]       req_idx_q;
  logic                    req_per_q;
  logic [TIMEOUT_BITS-1:0] dvd_q;
  logic [ROT_W-1:0]        quo_q;
  logic [SLOT_W-1:0]       rem_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [PROD_W-1:0]       rcp_prod;
  logic [TIMEOUT_BITS-1:0] quo_slots;
  logic                    div_done;

  assign rcp_prod  = {{RCP_W{1'b0}}, dvd_q} * {{TIMEOUT_BITS{1'b0}}, RCP};
  assign quo_slots = TIMEOUT_BITS'(quo_q) * SLOTS_T;
  assign div_done  = cnt_q == DIV_STEPS;

  // Latch request, then split ticks by SLOTS: quotient by reciprocal multiply,
  // remainder on the next cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_idx_q <= TIDX_W'(in_id);
      req_per_q <= in_per;
      dvd_q     <= (in_tmo == '0) ? TIMEOUT_BITS'(1) : in_tmo;
      quo_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
    end else if (cmd_i.div_step && !div_done) begin
      if (cnt_q == '0) begin
        quo_q <= rcp_prod[RCP_SH +: ROT_W];
      end else begin
        rem_q <= SLOT_W'(dvd_q - quo_slots);
      end
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // Control state
  logic [TIMERS-1:0] armed_q;
  logic [SLOT_W-1:0] cur_q;
  logic [TIDX_W-1:0] eval_idx_q;
  logic              pend_valid_q, out_valid_q;
  logic [ID_W-1:0]   pend_id_q, out_id_q;
  logic              out_last_q;

  // Timer table
  entry_t            arm_ent, rd_ent, nxt_ent;
  logic [ENT_W-1:0]  rd_data;
  logic              ram_we;
  logic [TIDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata;

  htw_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TIMERS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd_data)
  );

  assign rd_ent = entry_t'(rd_data);

  // Entry written on add or adjust
  always_comb begin
    arm_ent.per    = req_per_q;
    arm_ent.reload = quo_q;
    arm_ent.offset = rem_q;
    arm_ent.slot   = slot_add(cur_q, rem_q);
    arm_ent.rot    = quo_q;
  end

  // Evaluate the scanned entry
  logic              hit, fire, countdown, out_free, stall, fire_go, last_idx;
  logic              flush_ok, flush_push, out_load;
  logic [SLOT_W-1:0] wake_slot;

  assign last_idx   = eval_idx_q == LAST_IDX;
  assign hit        = cmd_i.scan && armed_q[eval_idx_q] && (rd_ent.slot == cur_q);
  assign fire       = hit && (rd_ent.rot == '0);
  assign countdown  = hit && (rd_ent.rot != '0);
  assign out_free   = !out_valid_q || out_ready_i;
  assign stall      = fire && pend_valid_q && !out_free;
  assign fire_go    = fire && !stall;
  assign wake_slot  = slot_add(cur_q, rd_ent.offset);
  assign flush_ok   = !pend_valid_q || out_free;
  assign flush_push = cmd_i.flush && pend_valid_q && out_free;
  assign out_load   = (fire_go && pend_valid_q) || flush_push;

  // Count down, or re-arm a periodic timer that fired
  always_comb begin
    nxt_ent = rd_ent;
    if (countdown) begin
      nxt_ent.rot = rd_ent.rot - ROT_W'(1);
    end else begin
      nxt_ent.slot = wake_slot;
      if ((wake_slot == cur_q) && (rd_ent.reload != '0)) begin
        nxt_ent.rot = rd_ent.reload - ROT_W'(1);
      end else begin
        nxt_ent.rot = rd_ent.reload;
      end
    end
  end

  // Table port selection
  always_comb begin
    ram_we    = cmd_i.arm_wr || countdown || (fire_go && rd_ent.per);
    ram_waddr = cmd_i.arm_wr ? req_idx_q : eval_idx_q;
    ram_wdata = cmd_i.arm_wr ? arm_ent : nxt_ent;
    if (cmd_i.prime) begin
      ram_raddr = '0;
    end else if (cmd_i.scan && !stall && !last_idx) begin
      ram_raddr = eval_idx_q + TIDX_W'(1);
    end else begin
      ram_raddr = eval_idx_q;
    end
  end

  // Armed flags, wheel position, scan index, pending and output stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q      <= '0;
      cur_q        <= '0;
      eval_idx_q   <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept && (in_req == REQ_REMOVE) && in_id_ok) begin
        armed_q[TIDX_W'(in_id)] <= 1'b0;
      end
      if (cmd_i.arm_wr) begin
        armed_q[req_idx_q] <= 1'b1;
      end
      if (fire_go && !rd_ent.per) begin
        armed_q[eval_idx_q] <= 1'b0;
      end

      if (cmd_i.prime) begin
        eval_idx_q <= '0;
      end else if (cmd_i.scan && !stall && !last_idx) begin
        eval_idx_q <= eval_idx_q + TIDX_W'(1);
      end

      if (fire_go) begin
        pend_valid_q <= 1'b1;
      end else if (flush_push) begin
        pend_valid_q <= 1'b0;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.flush && flush_ok) begin
        cur_q <= (cur_q == LAST_SLOT) ? '0 : cur_q + SLOT_W'(1);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (fire_go) begin
      pend_id_q <= ID_W'(eval_idx_q);
    end
    if (out_load) begin
      out_id_q   <= pend_id_q;
      out_last_q <= flush_push;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = OUT_DATA_W'(out_id_q);
  assign out_last_o  = out_last_q;

  // Status
  always_comb begin
    sts_o.req_tick = in_req == REQ_TICK;
    sts_o.req_arm  = (in_req == REQ_ADD) || (in_req == REQ_ADJUST);
    sts_o.id_ok    = in_id_ok;
    sts_o.div_done = div_done;
    sts_o.scan_end = cmd_i.scan && last_idx && !stall;
    sts_o.flush_ok = flush_ok;
  end

endmodule

// ----- design/hashed_timing_wheel_unit.sv -----
// Add and adjust step through accepting the request, the reciprocal multiply that gives
// the rounds, the slot offset, closing the split and writing the table.
// Remove and out-of-table requests are done once accepted.
// A tick scans one table entry per cycle through the single read port, except while
// the result stream is held back.
// Reset clears every armed flag and the wheel position; table entries are not cleared.
`timescale 1ns / 1ps

module hashed_timing_wheel_unit #(
  parameter int unsigned SLOTS  = 1024,
  parameter int unsigned TIMERS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [4:0] timer_id, [24:5] timeout, [25] periodic, [31:26] zero
  input  logic [htw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] req_type
  input  logic [htw_pkg::REQ_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [4:0] fired_id, [7:5] zero
  output logic [htw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  import htw_pkg::*;

  htw_cmd_t cmd;
  htw_sts_t sts;

  // Sequencer
  htw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Timer table, divider and result stages
  htw_datapath #(
    .SLOTS (SLOTS),
    .TIMERS(TIMERS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_last_o (m_axis_tlast)
  );

endmodule

// ----- design/htw_checker.sv -----
`timescale 1ns / 1ps

module htw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [htw_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input logic [htw_pkg::REQ_W-1:0]       s_axis_tuser,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [htw_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tlast
);

  import htw_pkg::*;

  logic in_xfer;

  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // A request other than a tick never starts a result
  a_no_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser != REQ_TICK) && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared after a non-tick request");

  // A tick holds off the next request while the table is scanned
  a_tick_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser == REQ_TICK) |=> !s_axis_tready)
    else $error("request taken during a tick scan");

  // Hold a result until its transfer
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind hashed_timing_wheel_unit htw_checker u_htw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast)
);
